// ----- design/hbv_pkg.sv -----
// shared types, constants and cell geometry functions for the heightfield block voxelizer
package hbv_pkg;

    localparam int HEIGHT_FRAC_BITS = 8;
    localparam int CELL_EDGE        = 8;

    localparam int CORNER_W = 16;
    localparam int ROW_W    = 7;
    localparam int SPLIT_W  = 4;
    localparam int IDX_W    = $clog2(CELL_EDGE);
    localparam int CENTRE_W = IDX_W + 1;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // interpolation widths
    localparam int WEIGHT_W = CENTRE_W + 1;
    localparam int U_W      = CORNER_W + WEIGHT_W - 1;
    localparam int H_W      = U_W + WEIGHT_W - 1;
    localparam int W_W      = ROW_W + CENTRE_W + CENTRE_W + HEIGHT_FRAC_BITS;
    localparam int CMP_W    = ((W_W > H_W) ? W_W : H_W) + 2;

    // full block test widths
    localparam int THR_W     = ROW_W + 1 + HEIGHT_FRAC_BITS;
    localparam int MN_CMP_W  = ((THR_W + 1) > CORNER_W) ? (THR_W + 1) : CORNER_W;
    localparam int ONE_VOXEL = 1 << HEIGHT_FRAC_BITS;

    // register indexes
    localparam logic [1:0] REG_SPLIT_ACROSS = 2'd0;
    localparam logic [1:0] REG_SPLIT_UP     = 2'd1;
    localparam logic [1:0] REG_SINGLE_COLOR = 2'd2;

    // legal split codes
    localparam logic [SPLIT_W-1:0] SPLIT_1 = 4'd1;
    localparam logic [SPLIT_W-1:0] SPLIT_2 = 4'd2;
    localparam logic [SPLIT_W-1:0] SPLIT_3 = 4'd3;
    localparam logic [SPLIT_W-1:0] SPLIT_4 = 4'd4;
    localparam logic [SPLIT_W-1:0] SPLIT_8 = 4'd8;

    typedef enum logic [1:0] {
        KIND_DETAILED = 2'd0,
        KIND_DIRT     = 2'd1,
        KIND_BEDROCK  = 2'd2
    } block_kind_t;

    localparam logic [1:0] MAT_GRASS = 2'd0;
    localparam logic [1:0] MAT_DIRT  = 2'd1;

    function automatic logic split_ok(input logic [SPLIT_W-1:0] s);
        return (s == SPLIT_1) || (s == SPLIT_2) || (s == SPLIT_3) ||
               (s == SPLIT_4) || (s == SPLIT_8);
    endfunction

    // cell width in sub-steps of the block edge
    function automatic logic [CENTRE_W-1:0] cell_size(input logic [SPLIT_W-1:0] s,
                                                      input logic [IDX_W-1:0] c);
        logic [CENTRE_W-1:0] r;
        unique case (s)
            SPLIT_2: r = 4'd4;
            SPLIT_3: r = (c == 3'd1) ? 4'd2 : 4'd3;
            SPLIT_4: r = 4'd2;
            SPLIT_8: r = 4'd1;
            default: r = 4'd8;
        endcase
        return r;
    endfunction

    // cell centre in units of 1/(2*CELL_EDGE) block
    function automatic logic [CENTRE_W-1:0] cell_centre(input logic [SPLIT_W-1:0] s,
                                                        input logic [IDX_W-1:0] c);
        logic [CENTRE_W-1:0] r;
        unique case (s)
            SPLIT_2: r = {c[0], 3'b100};
            SPLIT_3: begin
                unique case (c)
                    3'd0:    r = 4'd3;
                    3'd1:    r = 4'd8;
                    default: r = 4'd13;
                endcase
            end
            SPLIT_4: r = {c[1:0], 2'b10};
            SPLIT_8: r = {c[2:0], 1'b1};
            default: r = 4'd8;
        endcase
        return r;
    endfunction

endpackage

// ----- design/heightfield_block_voxelizer.sv -----
// heightfield block voxelizer: block classifier, column sequencer and masking pipeline
// pipeline: an accepted request passes the sequencer, three arithmetic stages and the
// output register; one result column leaves per cycle while m_tready does not stall it
// columns: a full block yields one result column, a detailed block split_across^2, issued by
// the column sequencer one column per cycle into the pipeline unless the stages stall
// reset: aresetn low at a rising edge clears all valid bits and sets the registers to
// split_across 2, split_up 2, single_color 0
module heightfield_block_voxelizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // corner_a, corner_b, corner_c, corner_d, block_row, zero pad
    input  logic [hbv_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // block_kind, column_x, column_z, filled_mask, grass_mask, fallback_material,
    // any_filled, zero pad
    output logic [hbv_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hbv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hbv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hbv_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import hbv_pkg::*;

    // configuration
    logic [SPLIT_W-1:0] split_across_reg;
    logic [SPLIT_W-1:0] split_up_reg;
    logic               single_color_reg;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_across_reg <= SPLIT_2;
            split_up_reg     <= SPLIT_2;
            single_color_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SPLIT_ACROSS: begin
                    if (split_ok(pwdata[SPLIT_W-1:0])) split_across_reg <= pwdata[SPLIT_W-1:0];
                end
                REG_SPLIT_UP: begin
                    if (split_ok(pwdata[SPLIT_W-1:0])) split_up_reg <= pwdata[SPLIT_W-1:0];
                end
                REG_SINGLE_COLOR: single_color_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SPLIT_ACROSS: prdata = APB_DATA_W'(split_across_reg);
            REG_SPLIT_UP:     prdata = APB_DATA_W'(split_up_reg);
            REG_SINGLE_COLOR: prdata = APB_DATA_W'(single_color_reg);
            default:          prdata = '0;
        endcase
    end

    // request unpack and classification
    logic signed [CORNER_W-1:0] in_a, in_b, in_c, in_d, min_ab, min_cd, in_min;
    logic [ROW_W-1:0]           in_row;
    logic [THR_W-1:0]           dirt_thr;
    logic signed [MN_CMP_W-1:0] min_x;
    logic                       is_bed, is_dirt;
    block_kind_t                in_kind;

    assign in_a   = s_tdata[15:0];
    assign in_b   = s_tdata[31:16];
    assign in_c   = s_tdata[47:32];
    assign in_d   = s_tdata[63:48];
    assign in_row = s_tdata[70:64];

    assign min_ab   = (in_b < in_a) ? in_b : in_a;
    assign min_cd   = (in_d < in_c) ? in_d : in_c;
    assign in_min   = (min_cd < min_ab) ? min_cd : min_ab;
    assign min_x    = MN_CMP_W'(in_min);
    assign dirt_thr = (THR_W'(in_row) + THR_W'(2)) << HEIGHT_FRAC_BITS;
    assign is_bed   = (in_row == '0) && (min_x >= $signed(MN_CMP_W'(ONE_VOXEL)));
    assign is_dirt  = min_x >= $signed(MN_CMP_W'(dirt_thr));

    always_comb begin
        priority if (is_bed) in_kind = KIND_BEDROCK;
        else if (is_dirt)    in_kind = KIND_DIRT;
        else                 in_kind = KIND_DETAILED;
    end

    // handshake chain
    logic out_load, s3_load, s2_load, s1_load, issue, accept, col_last;
    logic m_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg, item_valid_reg;

    assign out_load = !m_valid_reg || m_tready;
    assign s3_load  = !s3_valid_reg || out_load;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign issue    = item_valid_reg && s1_load;
    assign s_tready = !item_valid_reg || (s1_load && col_last);
    assign accept   = s_tvalid && s_tready;

    // column sequencer
    logic signed [CORNER_W-1:0] it_a_reg, it_b_reg, it_c_reg, it_d_reg;
    logic [ROW_W-1:0]           it_row_reg;
    block_kind_t                it_kind_reg;
    logic [IDX_W-1:0]           cnt_x_reg, cnt_z_reg;
    logic [SPLIT_W-1:0]         across_max;

    assign across_max = split_across_reg - SPLIT_W'(1);
    assign col_last   = (it_kind_reg != KIND_DETAILED) ||
                        ((cnt_x_reg == across_max[IDX_W-1:0]) &&
                         (cnt_z_reg == across_max[IDX_W-1:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            cnt_x_reg      <= '0;
            cnt_z_reg      <= '0;
        end else if (accept) begin
            item_valid_reg <= 1'b1;
            cnt_x_reg      <= '0;
            cnt_z_reg      <= '0;
        end else if (issue) begin
            if (col_last) begin
                item_valid_reg <= 1'b0;
            end else if (cnt_x_reg == across_max[IDX_W-1:0]) begin
                cnt_x_reg <= '0;
                cnt_z_reg <= cnt_z_reg + IDX_W'(1);
            end else begin
                cnt_x_reg <= cnt_x_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            it_a_reg    <= in_a;
            it_b_reg    <= in_b;
            it_c_reg    <= in_c;
            it_d_reg    <= in_d;
            it_row_reg  <= in_row;
            it_kind_reg <= in_kind;
        end
    end

    // stage 1: blend along x
    logic [CENTRE_W-1:0]        px, pz;
    logic signed [WEIGHT_W-1:0] wx_hi, wx_lo;
    logic signed [U_W-1:0]      u_next, v_next;

    assign px     = cell_centre(split_across_reg, cnt_x_reg);
    assign pz     = cell_centre(split_across_reg, cnt_z_reg);
    assign wx_lo  = $signed({1'b0, px});
    assign wx_hi  = $signed(WEIGHT_W'(2 * CELL_EDGE)) - wx_lo;
    assign u_next = U_W'(wx_hi * it_a_reg + wx_lo * it_b_reg);
    assign v_next = U_W'(wx_hi * it_c_reg + wx_lo * it_d_reg);

    logic signed [U_W-1:0] s1_u_reg, s1_v_reg;
    logic [CENTRE_W-1:0]   s1_pz_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    block_kind_t           s1_kind_reg;
    logic [IDX_W-1:0]      s1_x_reg, s1_z_reg;
    logic                  s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_load) begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_u_reg    <= u_next;
            s1_v_reg    <= v_next;
            s1_pz_reg   <= pz;
            s1_row_reg  <= it_row_reg;
            s1_kind_reg <= it_kind_reg;
            s1_x_reg    <= cnt_x_reg;
            s1_z_reg    <= cnt_z_reg;
            s1_last_reg <= col_last;
        end
    end

    // stage 2: blend along z
    logic signed [WEIGHT_W-1:0] wz_hi, wz_lo;
    logic signed [H_W-1:0]      h_next;

    assign wz_lo  = $signed({1'b0, s1_pz_reg});
    assign wz_hi  = $signed(WEIGHT_W'(2 * CELL_EDGE)) - wz_lo;
    assign h_next = H_W'(wz_hi * s1_u_reg + wz_lo * s1_v_reg);

    logic signed [H_W-1:0] s2_h_reg;
    logic [ROW_W-1:0]      s2_row_reg;
    block_kind_t           s2_kind_reg;
    logic [IDX_W-1:0]      s2_x_reg, s2_z_reg;
    logic                  s2_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_load) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_load) begin
            s2_h_reg    <= h_next;
            s2_row_reg  <= s1_row_reg;
            s2_kind_reg <= s1_kind_reg;
            s2_x_reg    <= s1_x_reg;
            s2_z_reg    <= s1_z_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // stage 3: per up-cell compare lanes
    logic [CELL_EDGE-1:0] fill_next, grass_next;

    always_comb begin
        logic [CENTRE_W-1:0]     cy;
        logic [W_W-1:0]          wy, thick;
        logic signed [CMP_W-1:0] diff;
        for (int y = 0; y < CELL_EDGE; y++) begin
            cy    = cell_centre(split_up_reg, IDX_W'(y));
            wy    = {s2_row_reg, cy, {CENTRE_W{1'b0}}, {HEIGHT_FRAC_BITS{1'b0}}};
            thick = W_W'(cell_size(split_up_reg, IDX_W'(y))) << (CENTRE_W + 1 + HEIGHT_FRAC_BITS);
            diff  = CMP_W'(s2_h_reg) - $signed(CMP_W'(wy));
            fill_next[y]  = (SPLIT_W'(y) < split_up_reg) && (diff > $signed(CMP_W'(0)));
            grass_next[y] = fill_next[y] && (s2_row_reg != '0) &&
                            (diff <= $signed(CMP_W'(thick)));
        end
    end

    logic [CELL_EDGE-1:0] s3_fill_reg, s3_grass_reg;
    block_kind_t          s3_kind_reg;
    logic [IDX_W-1:0]     s3_x_reg, s3_z_reg;
    logic                 s3_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_load) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_load) begin
            s3_fill_reg  <= fill_next;
            s3_grass_reg <= grass_next;
            s3_kind_reg  <= s2_kind_reg;
            s3_x_reg     <= s2_x_reg;
            s3_z_reg     <= s2_z_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    // output stage: block-wide flags and result register
    logic                 acc_any_reg, acc_grass_reg, any_next, has_grass_next, s3_move;
    logic [OUT_DATA_W-1:0] m_data_reg, data_next;
    logic                 m_last_reg;
    logic [1:0]           fallback;

    assign s3_move        = s3_valid_reg && out_load;
    assign any_next       = acc_any_reg || (s3_fill_reg != '0);
    assign has_grass_next = acc_grass_reg || (s3_grass_reg != '0);

    always_comb begin
        data_next = '0;
        fallback  = has_grass_next ? MAT_GRASS : MAT_DIRT;
        if (s3_kind_reg != KIND_DETAILED) begin
            data_next[1:0]   = s3_kind_reg;
            data_next[15:8]  = 8'd1;
            data_next[25:24] = s3_kind_reg;
            data_next[26]    = 1'b1;
        end else begin
            data_next[1:0]   = KIND_DETAILED;
            data_next[4:2]   = s3_x_reg;
            data_next[7:5]   = s3_z_reg;
            data_next[15:8]  = s3_fill_reg;
            data_next[23:16] = single_color_reg ? '0 : s3_grass_reg;
            if (s3_last_reg) begin
                data_next[25:24] = fallback;
                data_next[26]    = any_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            acc_any_reg   <= 1'b0;
            acc_grass_reg <= 1'b0;
        end else begin
            if (out_load) m_valid_reg <= s3_valid_reg;
            if (s3_move) begin
                acc_any_reg   <= s3_last_reg ? 1'b0 : any_next;
                acc_grass_reg <= s3_last_reg ? 1'b0 : has_grass_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= data_next;
            m_last_reg <= s3_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // checks
    a_flags_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[26:24] == 3'd0)
        else $error("block flags on a result that is not last");

    a_full_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != KIND_DETAILED) |-> m_tlast)
        else $error("full block result without last");

    a_seq_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        issue && col_last && !accept |=> !item_valid_reg)
        else $error("sequencer kept a finished request");

    a_split_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        split_ok(split_across_reg) && split_ok(split_up_reg))
        else $error("split register holds an unsupported value");

endmodule

// ----- bench/hbv_column_checker.sv -----
// column checker: predicts the result columns of each block request and compares them
module hbv_column_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [hbv_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [hbv_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [hbv_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hbv_pkg::APB_DATA_W-1:0] pwdata,
    output int                             fails,
    output int                             pending
);
    import hbv_pkg::*;

    typedef struct packed {
        block_kind_t kind;
        logic [2:0]  col_x;
        logic [2:0]  col_z;
        logic [7:0]  filled;
        logic [7:0]  grass;
        logic [1:0]  fallback;
        logic        any_filled;
        logic        last;
    } column_t;

    localparam logic [1:0] MAT_BEDROCK = 2'd2;
    localparam longint     EDGE2       = 2 * CELL_EDGE;
    localparam longint     UNIT        = longint'(1) << HEIGHT_FRAC_BITS;

    logic [SPLIT_W-1:0] across_q;
    logic [SPLIT_W-1:0] up_q;
    logic               single_q;
    column_t            expected_columns[$];

    function automatic logic split_legal(input logic [SPLIT_W-1:0] s);
        case (s)
            SPLIT_1, SPLIT_2, SPLIT_3, SPLIT_4, SPLIT_8: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // cell width in eighths of the block edge
    function automatic longint span_of(input logic [SPLIT_W-1:0] s, input int c);
        if (s == SPLIT_3) begin
            return (c == 1) ? 2 : 3;
        end
        return CELL_EDGE / s;
    endfunction

    // cell middle in sixteenths of the block edge
    function automatic longint mid_of(input logic [SPLIT_W-1:0] s, input int c);
        longint start;
        if (s == SPLIT_3) begin
            start = (c == 0) ? 0 : (c == 1) ? 3 : 5;
        end else begin
            start = c * span_of(s, c);
        end
        return 2 * start + span_of(s, c);
    endfunction

    task automatic voxelize_block(input logic [IN_DATA_W-1:0] d);
        longint  ca, cb, cc, cd, row, low, h, w, thick, px, pz;
        int      x, z, y;
        logic    bed, any, grassy;
        column_t col;
        ca  = longint'($signed(d[15:0]));
        cb  = longint'($signed(d[31:16]));
        cc  = longint'($signed(d[47:32]));
        cd  = longint'($signed(d[63:48]));
        row = longint'(d[70:64]);
        low = ca;
        if (cb < low) low = cb;
        if (cc < low) low = cc;
        if (cd < low) low = cd;
        bed = (row == 0) && (low >= UNIT);
        if (bed || low >= (row + 2) * UNIT) begin
            col            = '0;
            col.kind       = bed ? KIND_BEDROCK : KIND_DIRT;
            col.filled     = 8'd1;
            col.fallback   = bed ? MAT_BEDROCK : MAT_DIRT;
            col.any_filled = 1'b1;
            col.last       = 1'b1;
            expected_columns = {expected_columns, col};
            return;
        end
        any    = 1'b0;
        grassy = 1'b0;
        for (z = 0; z < across_q; z++) begin
            pz = mid_of(across_q, z);
            for (x = 0; x < across_q; x++) begin
                px = mid_of(across_q, x);
                h  = (EDGE2 - pz) * ((EDGE2 - px) * ca + px * cb)
                   + pz * ((EDGE2 - px) * cc + px * cd);
                col       = '0;
                col.kind  = KIND_DETAILED;
                col.col_x = x[2:0];
                col.col_z = z[2:0];
                for (y = 0; y < up_q; y++) begin
                    w     = (row * EDGE2 + mid_of(up_q, y)) * EDGE2 * UNIT;
                    thick = 2 * span_of(up_q, y) * EDGE2 * UNIT;
                    if (w < h) begin
                        col.filled[y] = 1'b1;
                        any = 1'b1;
                        if (row > 0 && h - w <= thick) begin
                            col.grass[y] = 1'b1;
                            grassy = 1'b1;
                        end
                    end
                end
                if (single_q) col.grass = '0;
                if (z == across_q - 1 && x == across_q - 1) begin
                    col.fallback   = grassy ? MAT_GRASS : MAT_DIRT;
                    col.any_filled = any;
                    col.last       = 1'b1;
                end
                expected_columns = {expected_columns, col};
            end
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin : watch
        column_t want, got;
        if (!aresetn) begin
            expected_columns.delete();
            across_q = SPLIT_2;
            up_q     = SPLIT_2;
            single_q = 1'b0;
            fails    = 0;
            pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_columns.size() == 0) begin
                    $display("%0t: column expected none, got %h last %b",
                             $time, m_tdata, m_tlast);
                    fails++;
                end else begin
                    want = expected_columns.pop_front();
                    got  = {m_tdata[1:0], m_tdata[4:2], m_tdata[7:5], m_tdata[15:8],
                            m_tdata[23:16], m_tdata[25:24], m_tdata[26], m_tlast};
                    check_field("block_kind", want.kind, got.kind);
                    check_field("column_x", want.col_x, got.col_x);
                    check_field("column_z", want.col_z, got.col_z);
                    check_field("filled_mask", want.filled, got.filled);
                    check_field("grass_mask", want.grass, got.grass);
                    check_field("fallback_material", want.fallback, got.fallback);
                    check_field("any_filled", want.any_filled, got.any_filled);
                    check_field("last", want.last, got.last);
                end
            end
            if (s_tvalid && s_tready) voxelize_block(s_tdata);
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SPLIT_ACROSS: if (split_legal(pwdata[3:0])) across_q = pwdata[3:0];
                    REG_SPLIT_UP:     if (split_legal(pwdata[3:0])) up_q = pwdata[3:0];
                    REG_SINGLE_COLOR: single_q = pwdata[0];
                    default: ;
                endcase
            end
            pending <= expected_columns.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// testbench top: block requests, register writes, result stalls and the final verdict
module tb;
    import hbv_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         PHASES     = 8;
    localparam int         PHASE_LEN  = 25;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fails;
    int                    pending;

    int         burst_left = 0;
    logic [7:0] stall_tick = '0;
    int         stall_mode = 0;

    int across_tab[PHASES] = '{1, 8, 3, 4, 8, 3, 2, 1};
    int up_tab[PHASES]     = '{1, 8, 3, 8, 2, 4, 1, 8};
    int single_tab[PHASES] = '{0, 1, 0, 0, 1, 1, 0, 1};

    heightfield_block_voxelizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hbv_column_checker column_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .fails    (fails),
        .pending  (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result stalls: pattern is redrawn whenever the low six bits of stall_tick wrap to zero
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 8'd1;
        if (stall_tick[5:0] == 6'd0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (stall_tick[1:0] == 2'd3);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    function automatic logic [IN_DATA_W-1:0] pack_block(input int a,
                                                        input int b,
                                                        input int c,
                                                        input int d,
                                                        input int row);
        return {1'b0, 7'(row), 16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_block();
        int row, base, spread, pick, i;
        int h[4];
        pick   = $urandom_range(0, 9);
        row    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
        spread = ($urandom_range(0, 1) == 0) ? 64 : 600;
        base   = row * 256 + int'($urandom_range(0, 640)) - 64;
        for (i = 0; i < 4; i++) begin
            if (pick == 0) h[i] = int'($urandom_range(0, 65535)) - 32768;
            else if (pick == 1) h[i] = (row + 2) * 256 + int'($urandom_range(0, 200));
            else h[i] = base + int'($urandom_range(0, 2 * spread)) - spread;
            if (h[i] > 32767) h[i] = 32767;
            if (h[i] < -32768) h[i] = -32768;
        end
        if (pick == 0) row = $urandom_range(0, 127);
        return pack_block(h[0], h[1], h[2], h[3], row);
    endfunction

    task automatic send_block(input logic [IN_DATA_W-1:0] blk);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        s_tdata  <= blk;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold requests until every expected column has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int p, k;
        aresetn  = 1'b0;
        s_tdata  = '0;
        s_tvalid = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_block(pack_block(0, 0, 0, 0, 0));
        send_block(pack_block(256, 256, 256, 256, 0));
        send_block(pack_block(255, 300, 300, 300, 0));
        send_block(pack_block(32767, 32767, 32767, 32767, 0));
        send_block(pack_block(1280, 1280, 1280, 1280, 3));
        send_block(pack_block(1279, 1280, 1280, 1280, 3));
        send_block(pack_block(32767, 32767, 32767, 32767, 127));
        send_block(pack_block(32767, 32767, 32767, 32767, 125));
        send_block(pack_block(-32768, -32768, -32768, -32768, 0));
        send_block(pack_block(-32768, -32768, -32768, -32768, 127));
        send_block(pack_block(32767, -32768, -32768, 32767, 1));
        send_block(pack_block(-32768, 32767, 32767, -32768, 127));
        send_block(pack_block(320, 320, 320, 320, 1));
        send_block(pack_block(321, 321, 321, 321, 1));
        send_block(pack_block(384, 384, 384, 384, 1));
        send_block(pack_block(128, 128, 128, 128, 0));
        send_block(pack_block(0, 512, 256, 768, 1));
        send_block(pack_block(32767, 32767, 32767, -32768, 0));
        send_block(pack_block(300, 300, 300, 300, 1));
        send_block(pack_block(1536, 600, 700, 800, 2));
        send_block(pack_block(-1, -1, -1, -1, 0));
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            reg_write(REG_SPLIT_ACROSS, $urandom);
            reg_write(REG_SPLIT_UP, $urandom);
            reg_write(REG_UNUSED, $urandom);
            reg_write(REG_SPLIT_ACROSS, ($urandom & 32'hFFFF_FFF0) | across_tab[p]);
            reg_write(REG_SPLIT_UP, ($urandom & 32'hFFFF_FFF0) | up_tab[p]);
            reg_write(REG_SINGLE_COLOR, ($urandom & 32'hFFFF_FFFE) | single_tab[p]);
            for (k = 0; k < PHASE_LEN; k++) begin
                if (k == 12) wait_drained();
                send_block(random_block());
            end
            wait_drained();
        end

        repeat (12) @(posedge aclk);
        if (fails == 0) begin
            $display("heightfield_block_voxelizer: match");
        end else begin
            $display("heightfield_block_voxelizer: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("heightfield_block_voxelizer: mismatch");
        $finish;
    end

endmodule
